/* rtl/core/pvbu_pkg.sv */
// ----------------------------------------------------------------------------
// pvbu_pkg
// Shared constants, types and the CORDIC table for the bin phase update block.
// ----------------------------------------------------------------------------
package pvbu_pkg;

    localparam int FFT_LEN_DEF     = 1024;
    localparam int PHASE_BITS_DEF  = 20;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int BIN_W_DEF       = 10;

    localparam int HOP_W       = 11;
    localparam int RATIO_W     = 15;
    localparam int RATIO_FRAC  = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [HOP_W-1:0]   HOP_RESET   = 11'd256;
    localparam logic [HOP_W-1:0]   HOP_MIN     = 11'd1;
    localparam logic [HOP_W-1:0]   HOP_MAX     = 11'd1024;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 15'd4096;
    localparam logic [RATIO_W-1:0] RATIO_MIN   = 15'd1024;
    localparam logic [RATIO_W-1:0] RATIO_MAX   = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOP_SIZE      = 2'd0,
        REG_STRETCH_RATIO = 2'd1
    } cfg_reg_t;

    localparam logic CMD_BIN   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam int ANG_W      = 32;
    localparam int NSTEPS     = 28;
    localparam int GUARD_BITS = 4;
    localparam int GAIN_SHIFT = 24;
    localparam logic [23:0] INV_GAIN = 24'd10188014;

    localparam logic [ANG_W-1:0] ATAN_TURNS [NSTEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    typedef struct packed {
        logic en;
        logic clr_start;
    } upd_ctl_t;

    typedef struct packed {
        logic busy;
        logic q_valid;
    } upd_stat_t;

endpackage

/* rtl/core/pvbu_in_if.sv */
// ----------------------------------------------------------------------------
// pvbu_in_if
// Input bin channel: command, bin index and complex sample.
// ----------------------------------------------------------------------------
interface pvbu_in_if #(
    parameter int BIN_W    = pvbu_pkg::BIN_W_DEF,
    parameter int SAMPLE_W = pvbu_pkg::SAMPLE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [BIN_W-1:0]           bin_index;
    logic signed [SAMPLE_W-1:0] re_in;
    logic signed [SAMPLE_W-1:0] im_in;

    modport source (output valid, cmd, bin_index, re_in, im_in, input ready);
    modport sink   (input valid, cmd, bin_index, re_in, im_in, output ready);
endinterface

/* rtl/core/pvbu_out_if.sv */
// ----------------------------------------------------------------------------
// pvbu_out_if
// Output bin channel: bin index and rebuilt complex sample.
// ----------------------------------------------------------------------------
interface pvbu_out_if #(
    parameter int BIN_W    = pvbu_pkg::BIN_W_DEF,
    parameter int SAMPLE_W = pvbu_pkg::SAMPLE_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic [BIN_W-1:0]           bin_out;
    logic signed [SAMPLE_W-1:0] re_out;
    logic signed [SAMPLE_W-1:0] im_out;

    modport source (output valid, bin_out, re_out, im_out, input ready);
    modport sink   (input valid, bin_out, re_out, im_out, output ready);
endinterface

/* rtl/core/pvbu_cfg_if.sv */
// ----------------------------------------------------------------------------
// pvbu_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface pvbu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pvbu_pkg::CFG_IDX_W-1:0]  index;
    logic [pvbu_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/phase_vocoder_bin_phase_update.sv */
// ----------------------------------------------------------------------------
// phase_vocoder_bin_phase_update
// Phase vocoder bin update: CORDIC to polar, phase advance, CORDIC back.
// ----------------------------------------------------------------------------
// Takes one bin transaction per clock unless a full skid entry, a pending
// clear or a sweep holds it off, and returns its rebuilt bin through an input
// register, 28 vectoring CORDIC cells, a phase/magnitude stage, the per-bin
// phase store read and update (two stages), 28 rotating CORDIC cells, an
// output multiply stage and the output register, with a skid entry so the
// input keeps flowing while a result waits. Two bins that follow each other
// directly may be the same bin. After reset, and after each clear transaction
// once earlier bins have passed the phase store, the store is swept one entry
// per cycle over all FFT_LEN/2+1 entries (513 by default), and no bin
// transaction is taken meanwhile. Out-of-range bins and clears give no result.
module phase_vocoder_bin_phase_update #(
    parameter int FFT_LEN     = pvbu_pkg::FFT_LEN_DEF,
    parameter int PHASE_BITS  = pvbu_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = pvbu_pkg::SAMPLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    pvbu_in_if.sink      din,
    pvbu_out_if.source   dout,
    pvbu_cfg_if.sink     cfg
);
    localparam int PB     = PHASE_BITS;
    localparam int SW     = SAMPLE_BITS;
    localparam int NBINS  = FFT_LEN / 2 + 1;
    localparam int BW     = $clog2(NBINS);
    localparam int LOG    = $clog2(FFT_LEN);
    localparam int CW     = SW + 8;
    localparam int AW     = pvbu_pkg::ANG_W;
    localparam int NS     = pvbu_pkg::NSTEPS;
    localparam int BH_W   = BW + pvbu_pkg::HOP_W;
    localparam int RB_W   = pvbu_pkg::RATIO_W + BH_W;
    localparam int MP_W   = CW + 23;
    localparam int RP_W   = CW + 25;
    localparam int VSIDE  = 1 + BW + BH_W;
    localparam int OSHIFT = pvbu_pkg::GAIN_SHIFT + pvbu_pkg::GUARD_BITS;
    localparam logic [AW:0] PROUND = (AW+1)'((64'd1 << (AW - PB)) >> 1);
    localparam logic signed [RP_W-1:0] OROUND = RP_W'(64'd1 << (OSHIFT - 1));
    localparam logic signed [RP_W-1:0] SMAX = RP_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [RP_W-1:0] SMIN = -SMAX - RP_W'(1);

    logic [pvbu_pkg::HOP_W-1:0]   hop_reg;
    logic [pvbu_pkg::RATIO_W-1:0] ratio_reg;
    logic [pvbu_pkg::HOP_W-1:0]   hop_next;
    logic [pvbu_pkg::RATIO_W-1:0] ratio_next;

    logic en;
    logic in_accept;
    logic pend_reg;
    logic drained;

    logic                 s0_v_reg;
    logic [BW-1:0]        s0_bin_reg;
    logic signed [SW-1:0] s0_re_reg;
    logic signed [SW-1:0] s0_im_reg;
    logic [BH_W-1:0]      s0_bh_reg;

    logic                 vv [NS+1];
    logic signed [CW-1:0] vx [NS+1];
    logic signed [CW-1:0] vy [NS+1];
    logic [AW-1:0]        vz [NS+1];
    logic [VSIDE-1:0]     vs [NS+1];
    logic [NS:0]          vv_all;
    logic signed [CW-1:0] x_ext;
    logic signed [CW-1:0] y_ext;
    logic                 s0_zero;

    logic                 v_zero;
    logic [BW-1:0]        v_bin;
    logic [BH_W-1:0]      v_bh;
    logic [AW:0]          ang_sum;
    logic [RB_W-1:0]      rb;
    logic [LOG+PB-1:0]    e_wide;
    logic [LOG+12+PB-1:0] a_wide;

    logic                 p_v_reg;
    logic [BW-1:0]        p_bin_reg;
    logic [PB-1:0]        p_phase_reg;
    logic [MP_W-1:0]      p_magprod_reg;
    logic [PB-1:0]        p_expect_reg;
    logic [PB-1:0]        p_adv1_reg;

    pvbu_pkg::upd_ctl_t   upd_ctl;
    pvbu_pkg::upd_stat_t  upd_stat;
    logic                 u_valid;
    logic [BW-1:0]        u_bin;
    logic signed [CW-1:0] u_mag;
    logic [PB-1:0]        u_synth;

    logic                 rv [NS+1];
    logic signed [CW-1:0] rx [NS+1];
    logic signed [CW-1:0] ry [NS+1];
    logic [AW-1:0]        rz [NS+1];
    logic [BW-1:0]        rs [NS+1];
    logic [AW-1:0]        z_rot;

    logic                   r_v_reg;
    logic [BW-1:0]          r_bin_reg;
    logic signed [RP_W-1:0] r_cp_reg;
    logic signed [RP_W-1:0] r_sp_reg;
    logic signed [SW-1:0]   c_sat;
    logic signed [SW-1:0]   s_sat;

    logic                 out_v_reg;
    logic [BW-1:0]        out_bin_reg;
    logic signed [SW-1:0] out_re_reg;
    logic signed [SW-1:0] out_im_reg;
    logic                 skid_v_reg;
    logic [BW-1:0]        skid_bin_reg;
    logic signed [SW-1:0] skid_re_reg;
    logic signed [SW-1:0] skid_im_reg;

    function automatic logic signed [SW-1:0] round_sat(input logic signed [RP_W-1:0] p);
        logic signed [RP_W-1:0] sh;
        sh = (p + OROUND) >>> OSHIFT;
        if (sh > SMAX)
            return SW'(SMAX);
        else if (sh < SMIN)
            return SW'(SMIN);
        return SW'(sh);
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_comb
    begin
        hop_next   = cfg.data[pvbu_pkg::HOP_W-1:0];
        ratio_next = cfg.data[pvbu_pkg::RATIO_W-1:0];
        if (hop_next < pvbu_pkg::HOP_MIN)
            hop_next = pvbu_pkg::HOP_MIN;
        else if (hop_next > pvbu_pkg::HOP_MAX)
            hop_next = pvbu_pkg::HOP_MAX;
        if (ratio_next < pvbu_pkg::RATIO_MIN)
            ratio_next = pvbu_pkg::RATIO_MIN;
        else if (ratio_next > pvbu_pkg::RATIO_MAX)
            ratio_next = pvbu_pkg::RATIO_MAX;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_reg   <= pvbu_pkg::HOP_RESET;
            ratio_reg <= pvbu_pkg::RATIO_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (pvbu_pkg::cfg_reg_t'(cfg.index))
                pvbu_pkg::REG_HOP_SIZE:      hop_reg   <= hop_next;
                pvbu_pkg::REG_STRETCH_RATIO: ratio_reg <= ratio_next;
                default: ;
            endcase
        end
    end

    // input and clear control
    assign en        = !skid_v_reg;
    assign din.ready = en && !pend_reg && !upd_stat.busy;
    assign in_accept = din.valid && din.ready;

    always_comb
    begin
        for (int k = 0; k <= NS; k++)
            vv_all[k] = vv[k];
    end

    assign drained           = !(|vv_all) && !p_v_reg && !upd_stat.q_valid;
    assign upd_ctl.en        = en;
    assign upd_ctl.clr_start = pend_reg && drained;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            s0_v_reg <= 1'b0;
        end
        else
        begin
            if (in_accept && din.cmd == pvbu_pkg::CMD_CLEAR)
                pend_reg <= 1'b1;
            else if (upd_ctl.clr_start)
                pend_reg <= 1'b0;
            if (en)
                s0_v_reg <= in_accept && din.cmd == pvbu_pkg::CMD_BIN &&
                            din.bin_index <= BW'(NBINS - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_bin_reg <= din.bin_index;
            s0_re_reg  <= din.re_in;
            s0_im_reg  <= din.im_in;
            s0_bh_reg  <= BH_W'(din.bin_index) * BH_W'(hop_reg);
        end
    end

    // vectoring chain
    always_comb
    begin
        x_ext   = CW'(s0_re_reg) <<< pvbu_pkg::GUARD_BITS;
        y_ext   = CW'(s0_im_reg) <<< pvbu_pkg::GUARD_BITS;
        s0_zero = (s0_re_reg == '0) && (s0_im_reg == '0);
        vv[0]   = s0_v_reg;
        vs[0]   = {s0_zero, s0_bin_reg, s0_bh_reg};
        if (x_ext[CW-1])
        begin
            vx[0] = -x_ext;
            vy[0] = -y_ext;
            vz[0] = {1'b1, {(AW-1){1'b0}}};
        end
        else
        begin
            vx[0] = x_ext;
            vy[0] = y_ext;
            vz[0] = '0;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_vec
        pvbu_vec_cell #(.CW(CW), .SIDE_W(VSIDE), .STEP(k)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(vv[k]), .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]), .side_in(vs[k]),
            .valid_out(vv[k+1]), .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1]),
            .side_out(vs[k+1])
        );
    end

    // phase, magnitude, expected advance
    always_comb
    begin
        {v_zero, v_bin, v_bh} = vs[NS];
        ang_sum = {1'b0, vz[NS]} + PROUND;
        rb      = RB_W'(ratio_reg) * RB_W'(v_bh);
        e_wide  = {v_bh[LOG-1:0], {PB{1'b0}}} >> LOG;
        a_wide  = {rb[LOG+11:0], {PB{1'b0}}} >> (LOG + 12);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else if (en)
            p_v_reg <= vv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_bin_reg     <= v_bin;
            p_phase_reg   <= v_zero ? '0 : ang_sum[AW-PB +: PB];
            p_magprod_reg <= v_zero ? '0 : MP_W'(vx[NS][CW-2:0]) * MP_W'(pvbu_pkg::INV_GAIN);
            p_expect_reg  <= e_wide[PB-1:0];
            p_adv1_reg    <= a_wide[PB-1:0];
        end
    end

    pvbu_phase_update #(.PB(PB), .BW(BW), .NBINS(NBINS), .MP_W(MP_W), .CW(CW)) u_update (
        .clk(clk), .rst_n(rst_n), .ctl(upd_ctl), .ratio(ratio_reg),
        .p_valid(p_v_reg), .p_bin(p_bin_reg), .p_phase(p_phase_reg),
        .p_magprod(p_magprod_reg), .p_expect(p_expect_reg), .p_adv1(p_adv1_reg),
        .stat(upd_stat), .u_valid(u_valid), .u_bin(u_bin), .u_mag(u_mag), .u_synth(u_synth)
    );

    // rotating chain
    always_comb
    begin
        z_rot = AW'(u_synth) << (AW - PB);
        rv[0] = u_valid;
        rs[0] = u_bin;
        ry[0] = '0;
        if (z_rot[AW-1] ^ z_rot[AW-2])
        begin
            rx[0] = -u_mag;
            rz[0] = {~z_rot[AW-1], z_rot[AW-2:0]};
        end
        else
        begin
            rx[0] = u_mag;
            rz[0] = z_rot;
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_rot
        pvbu_rot_cell #(.CW(CW), .SIDE_W(BW), .STEP(k)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .valid_in(rv[k]), .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]), .side_in(rs[k]),
            .valid_out(rv[k+1]), .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1]),
            .side_out(rs[k+1])
        );
    end

    // gain correction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_v_reg <= 1'b0;
        else if (en)
            r_v_reg <= rv[NS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_bin_reg <= rs[NS];
            r_cp_reg  <= RP_W'(rx[NS]) * RP_W'($signed({1'b0, pvbu_pkg::INV_GAIN}));
            r_sp_reg  <= RP_W'(ry[NS]) * RP_W'($signed({1'b0, pvbu_pkg::INV_GAIN}));
        end
    end

    assign c_sat = round_sat(r_cp_reg);
    assign s_sat = round_sat(r_sp_reg);

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (en && r_v_reg)
        begin
            if (!out_v_reg || dout.ready)
                out_v_reg <= 1'b1;
            else
                skid_v_reg <= 1'b1;
        end
        else if (skid_v_reg)
        begin
            if (dout.ready)
                skid_v_reg <= 1'b0;
        end
        else if (dout.ready)
            out_v_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en && r_v_reg)
        begin
            if (!out_v_reg || dout.ready)
            begin
                out_bin_reg <= r_bin_reg;
                out_re_reg  <= c_sat;
                out_im_reg  <= s_sat;
            end
            else
            begin
                skid_bin_reg <= r_bin_reg;
                skid_re_reg  <= c_sat;
                skid_im_reg  <= s_sat;
            end
        end
        else if (skid_v_reg && dout.ready)
        begin
            out_bin_reg <= skid_bin_reg;
            out_re_reg  <= skid_re_reg;
            out_im_reg  <= skid_im_reg;
        end
    end

    assign dout.valid   = out_v_reg;
    assign dout.bin_out = out_bin_reg;
    assign dout.re_out  = out_re_reg;
    assign dout.im_out  = out_im_reg;

    // checks
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        upd_stat.busy |-> !din.ready)
        else $error("transaction accepted during phase store sweep");

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without output entry");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && drained && !upd_stat.busy) |=> upd_stat.busy)
        else $error("clear did not start sweep");

    a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
        upd_stat.busy |-> !upd_stat.q_valid)
        else $error("bin in phase update stage during sweep");
endmodule

/* rtl/core/pvbu_vec_cell.sv */
// ----------------------------------------------------------------------------
// pvbu_vec_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module pvbu_vec_cell #(
    parameter int CW     = 32,
    parameter int SIDE_W = 8,
    parameter int STEP   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic signed [CW-1:0]          x_in,
    input  logic signed [CW-1:0]          y_in,
    input  logic [pvbu_pkg::ANG_W-1:0]    z_in,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          valid_out,
    output logic signed [CW-1:0]          x_out,
    output logic signed [CW-1:0]          y_out,
    output logic [pvbu_pkg::ANG_W-1:0]    z_out,
    output logic [SIDE_W-1:0]             side_out
);
    logic                       valid_reg;
    logic signed [CW-1:0]       x_reg;
    logic signed [CW-1:0]       y_reg;
    logic [pvbu_pkg::ANG_W-1:0] z_reg;
    logic [SIDE_W-1:0]          side_reg;
    logic signed [CW-1:0]       dx;
    logic signed [CW-1:0]       dy;
    logic signed [CW-1:0]       x_next;
    logic signed [CW-1:0]       y_next;
    logic [pvbu_pkg::ANG_W-1:0] z_next;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (!y_in[CW-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + pvbu_pkg::ATAN_TURNS[STEP];
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - pvbu_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;
endmodule

/* rtl/core/pvbu_rot_cell.sv */
// ----------------------------------------------------------------------------
// pvbu_rot_cell
// One rotating CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module pvbu_rot_cell #(
    parameter int CW     = 32,
    parameter int SIDE_W = 8,
    parameter int STEP   = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_in,
    input  logic signed [CW-1:0]          x_in,
    input  logic signed [CW-1:0]          y_in,
    input  logic [pvbu_pkg::ANG_W-1:0]    z_in,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          valid_out,
    output logic signed [CW-1:0]          x_out,
    output logic signed [CW-1:0]          y_out,
    output logic [pvbu_pkg::ANG_W-1:0]    z_out,
    output logic [SIDE_W-1:0]             side_out
);
    logic                       valid_reg;
    logic signed [CW-1:0]       x_reg;
    logic signed [CW-1:0]       y_reg;
    logic [pvbu_pkg::ANG_W-1:0] z_reg;
    logic [SIDE_W-1:0]          side_reg;
    logic signed [CW-1:0]       dx;
    logic signed [CW-1:0]       dy;
    logic signed [CW-1:0]       x_next;
    logic signed [CW-1:0]       y_next;
    logic [pvbu_pkg::ANG_W-1:0] z_next;

    always_comb
    begin
        dx = y_in >>> STEP;
        dy = x_in >>> STEP;
        if (z_in[pvbu_pkg::ANG_W-1])
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + pvbu_pkg::ATAN_TURNS[STEP];
        end
        else
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - pvbu_pkg::ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;
endmodule

/* rtl/core/pvbu_phase_update.sv */
// ----------------------------------------------------------------------------
// pvbu_phase_update
// Per-bin phase store, deviation and synthesis phase update, clear sweep.
// ----------------------------------------------------------------------------
module pvbu_phase_update #(
    parameter int PB    = 20,
    parameter int BW    = 10,
    parameter int NBINS = 513,
    parameter int MP_W  = 55,
    parameter int CW    = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pvbu_pkg::upd_ctl_t              ctl,
    input  logic [pvbu_pkg::RATIO_W-1:0]    ratio,
    input  logic                            p_valid,
    input  logic [BW-1:0]                   p_bin,
    input  logic [PB-1:0]                   p_phase,
    input  logic [MP_W-1:0]                 p_magprod,
    input  logic [PB-1:0]                   p_expect,
    input  logic [PB-1:0]                   p_adv1,
    output pvbu_pkg::upd_stat_t             stat,
    output logic                            u_valid,
    output logic [BW-1:0]                   u_bin,
    output logic signed [CW-1:0]            u_mag,
    output logic [PB-1:0]                   u_synth
);
    localparam int PR_W = pvbu_pkg::RATIO_W + 1 + PB;
    localparam logic signed [PR_W-1:0] ADV_ROUND = PR_W'(1 << (pvbu_pkg::RATIO_FRAC - 1));
    localparam logic [MP_W:0] MAG_ROUND = (MP_W+1)'(1) << (pvbu_pkg::GAIN_SHIFT - 1);

    logic [2*PB-1:0]   mem [NBINS];
    logic [2*PB-1:0]   rd_reg;
    logic              q_v_reg;
    logic [BW-1:0]     q_bin_reg;
    logic [PB-1:0]     q_phase_reg;
    logic [MP_W-1:0]   q_magprod_reg;
    logic [PB-1:0]     q_expect_reg;
    logic [PB-1:0]     q_adv1_reg;
    logic              fwd_v_reg;
    logic [2*PB-1:0]   fwd_reg;
    logic              busy_reg;
    logic [BW-1:0]     cnt_reg;
    logic              u_v_reg;
    logic [BW-1:0]     u_bin_reg;
    logic signed [CW-1:0] u_mag_reg;
    logic [PB-1:0]     u_synth_reg;

    logic [2*PB-1:0]   old_ph;
    logic [PB-1:0]     dev;
    logic signed [PR_W-1:0] adv_prod;
    logic [PB-1:0]     adv2;
    logic [PB-1:0]     synth_next;
    logic [MP_W:0]     mag_sum;
    logic signed [CW-1:0] mag_next;

    always_comb
    begin
        old_ph     = fwd_v_reg ? fwd_reg : rd_reg;
        dev        = q_phase_reg - old_ph[2*PB-1:PB] - q_expect_reg;
        adv_prod   = PR_W'($signed({1'b0, ratio})) * PR_W'($signed(dev)) + ADV_ROUND;
        adv2       = adv_prod[pvbu_pkg::RATIO_FRAC +: PB];
        synth_next = old_ph[PB-1:0] + q_adv1_reg + adv2;
        mag_sum    = {1'b0, q_magprod_reg} + MAG_ROUND;
        mag_next   = mag_sum[pvbu_pkg::GAIN_SHIFT +: CW];
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            mem[cnt_reg] <= '0;
        else if (ctl.en && q_v_reg)
            mem[q_bin_reg] <= {q_phase_reg, synth_next};
        if (ctl.en)
            rd_reg <= mem[p_bin];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
            q_v_reg   <= 1'b0;
            u_v_reg   <= 1'b0;
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg)
            begin
                if (cnt_reg == BW'(NBINS - 1))
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                    cnt_reg <= cnt_reg + 1'b1;
            end
            else if (ctl.clr_start)
                busy_reg <= 1'b1;

            if (busy_reg)
                fwd_v_reg <= 1'b0;
            else if (ctl.en)
                fwd_v_reg <= q_v_reg && p_valid && (p_bin == q_bin_reg);

            if (ctl.en)
            begin
                q_v_reg <= p_valid;
                u_v_reg <= q_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            q_bin_reg     <= p_bin;
            q_phase_reg   <= p_phase;
            q_magprod_reg <= p_magprod;
            q_expect_reg  <= p_expect;
            q_adv1_reg    <= p_adv1;
            fwd_reg       <= {q_phase_reg, synth_next};
            u_bin_reg     <= q_bin_reg;
            u_mag_reg     <= mag_next;
            u_synth_reg   <= synth_next;
        end
    end

    assign stat.busy    = busy_reg;
    assign stat.q_valid = q_v_reg;
    assign u_valid      = u_v_reg;
    assign u_bin        = u_bin_reg;
    assign u_mag        = u_mag_reg;
    assign u_synth      = u_synth_reg;
endmodule
